@@ hw/rtl/rtlp_pkg.sv @@
package rtlp_pkg;

  // Table depth and derived widths
  localparam int MAX_ROUTES = 16;
  localparam int CNT_W      = $clog2(MAX_ROUTES + 1);
  localparam int ADDR_W     = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // One stored route
  typedef struct packed {
    logic [ADDR_W-1:0] dst;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gw;
  } entry_t;

  // Record that travels down the chain of cells with the scan token
  typedef struct packed {
    logic   tok;
    logic   hit;
    entry_t best;
  } scan_t;

endpackage

@@ hw/rtl/rtlp_ifs.sv @@
interface rtlp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] route_address;
  logic [31:0] route_mask;
  logic [31:0] route_gateway;

  modport source (output valid, operation, route_address, route_mask, route_gateway,
                  input ready);
  modport sink   (input valid, operation, route_address, route_mask, route_gateway,
                  output ready);
endinterface

interface rtlp_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        hit;
  logic [31:0] match_destination;
  logic [31:0] match_mask;
  logic [31:0] match_gateway;

  modport source (output valid, status, hit, match_destination, match_mask, match_gateway,
                  input ready);
  modport sink   (input valid, status, hit, match_destination, match_mask, match_gateway,
                  output ready);
endinterface

@@ hw/rtl/rtlp_cell.sv @@
module rtlp_cell
  import rtlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              occupied,
  input  logic              wr_en,
  input  entry_t            wr_data,
  input  entry_t            shift_data,
  input  logic [ADDR_W-1:0] req_addr,
  input  logic [ADDR_W-1:0] req_mask,
  input  logic              is_remove,
  input  scan_t             scan_in,
  output scan_t             scan_out,
  output entry_t            entry_out
);

  entry_t ent_r;
  scan_t  scan_r;
  scan_t  scan_nxt;
  logic   lkp_match;
  logic   rm_match;
  logic   shift_en;

  // Compare the request against the held route
  assign lkp_match = occupied
                  && (((req_addr ^ ent_r.dst) & ent_r.mask) == '0)
                  && (ent_r.mask >= scan_in.best.mask);
  assign rm_match  = occupied && (ent_r.dst == req_addr) && (ent_r.mask == req_mask);

  // Update the travelling record with this cell's verdict
  always_comb begin
    scan_nxt = scan_in;
    if (is_remove) begin
      scan_nxt.hit = scan_in.hit | rm_match;
    end else if (lkp_match) begin
      scan_nxt.hit  = 1'b1;
      scan_nxt.best = ent_r;
    end
  end

  // Close the gap: once the first match is seen, pull in the right neighbour
  assign shift_en = scan_in.tok && is_remove && scan_nxt.hit;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r <= wr_data;
    end else if (shift_en) begin
      ent_r <= shift_data;
    end
  end

  // Hand the record on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.tok <= 1'b0;
    end else begin
      scan_r.tok <= scan_nxt.tok;
    end
    scan_r.hit  <= scan_nxt.hit;
    scan_r.best <= scan_nxt.best;
  end

  assign scan_out  = scan_r;
  assign entry_out = ent_r;

endmodule

@@ hw/rtl/route_table_longest_prefix.sv @@
// Longest-prefix-match IPv4 route table, MAX_ROUTES entries in insertion order.
// in_chan carries one request word: operation (add, remove, flush, lookup),
// route_address, route_mask and route_gateway. out_chan returns one result word
// per request: status, hit and the matching route's destination, mask, gateway.
// Both channels move a word on a rising edge with valid and ready high.
// Add and flush finish in the accept cycle; their result word is valid on the
// next cycle. Lookup and remove send a token through the row of MAX_ROUTES
// cells, one cell per cycle, and their result word is registered when the
// token leaves the last cell. Requests are handled one at a time: a new
// word is accepted once the previous result is taken (or being taken), so
// add and flush can be accepted one per cycle while out_chan.ready stays high.
// A stalled result holds on out_chan and in_chan.ready stays low meanwhile.
// Synchronous reset (rst_n low) empties the table and drops any pending result;
// no clearing pass is needed, the route count alone marks entries as present.
module route_table_longest_prefix
  import rtlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rtlp_req_if.sink   in_chan,
  rtlp_rsp_if.source out_chan
);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t            state_r,    state_nxt;
  logic [CNT_W-1:0]  cnt_r,      cnt_nxt;
  logic [ADDR_W-1:0] req_addr_r, req_addr_nxt;
  logic [ADDR_W-1:0] req_mask_r, req_mask_nxt;
  logic              is_rm_r,    is_rm_nxt;
  logic              start_r,    start_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r,   status_nxt;
  logic              hit_r,      hit_nxt;
  entry_t            res_r,      res_nxt;

  logic   in_ready;
  logic   in_acc;
  logic   add_go;
  logic   scan_done;
  entry_t wr_data;
  scan_t  chain [MAX_ROUTES+1];
  entry_t ents  [MAX_ROUTES+1];

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc    = in_chan.valid && in_ready;
  assign add_go    = in_acc && (op_t'(in_chan.operation) == OP_ADD)
                  && (cnt_r < CNT_W'(MAX_ROUTES));
  assign scan_done = chain[MAX_ROUTES].tok;

  assign wr_data.dst  = in_chan.route_address;
  assign wr_data.mask = in_chan.route_mask;
  assign wr_data.gw   = in_chan.route_gateway;

  // Inject the scan token with an empty best-so-far record
  assign chain[0].tok  = start_r;
  assign chain[0].hit  = 1'b0;
  assign chain[0].best = '0;
  assign ents[MAX_ROUTES] = '0;

  // Row of route cells
  for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
    rtlp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .occupied   (cnt_r > CNT_W'(i)),
      .wr_en      (add_go && (cnt_r == CNT_W'(i))),
      .wr_data    (wr_data),
      .shift_data (ents[i+1]),
      .req_addr   (req_addr_r),
      .req_mask   (req_mask_r),
      .is_remove  (is_rm_r),
      .scan_in    (chain[i]),
      .scan_out   (chain[i+1]),
      .entry_out  (ents[i])
    );
  end

  // Sequence requests and build the result word
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    req_addr_nxt  = req_addr_r;
    req_mask_nxt  = req_mask_r;
    is_rm_nxt     = is_rm_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    status_nxt    = status_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          status_nxt = ST_OK;
          hit_nxt    = 1'b0;
          res_nxt    = '0;
          unique case (op_t'(in_chan.operation))
            OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (add_go) begin
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_FLUSH: begin
              out_valid_nxt = 1'b1;
              cnt_nxt       = '0;
            end
            OP_REMOVE, OP_LOOKUP: begin
              req_addr_nxt = in_chan.route_address;
              req_mask_nxt = in_chan.route_mask;
              is_rm_nxt    = (op_t'(in_chan.operation) == OP_REMOVE);
              start_nxt    = 1'b1;
              state_nxt    = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (is_rm_r) begin
            hit_nxt    = 1'b0;
            res_nxt    = '0;
            status_nxt = chain[MAX_ROUTES].hit ? ST_OK : ST_NOT_FOUND;
            if (chain[MAX_ROUTES].hit) begin
              cnt_nxt = cnt_r - 1'b1;
            end
          end else begin
            status_nxt = ST_OK;
            hit_nxt    = chain[MAX_ROUTES].hit;
            res_nxt    = chain[MAX_ROUTES].best;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, count and the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_addr_r <= req_addr_nxt;
    req_mask_r <= req_mask_nxt;
    is_rm_r    <= is_rm_nxt;
    status_r   <= status_nxt;
    hit_r      <= hit_nxt;
    res_r      <= res_nxt;
  end

  assign in_chan.ready              = in_ready;
  assign out_chan.valid             = out_valid_r;
  assign out_chan.status            = status_r;
  assign out_chan.hit               = hit_r;
  assign out_chan.match_destination = res_r.dst;
  assign out_chan.match_mask        = res_r.mask;
  assign out_chan.match_gateway     = res_r.gw;

endmodule
